FILE: rtl/core/kct_pkg.sv
// kct_pkg: shared types and constants for the keyed count table
// no dependencies; used by the interfaces, the core modules and the checker
package kct_pkg;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 32;
  localparam int USED_W = 7;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } alu_flags_t;

endpackage

FILE: rtl/core/kct_if.sv
// kct_in_if / kct_out_if: valid/ready channels for requests and results
// depends on kct_pkg for field widths
interface kct_in_if;
  logic                       valid;
  logic                       ready;
  logic [kct_pkg::OP_W-1:0]   op;
  logic [kct_pkg::KEY_W-1:0]  item_key;
  logic [kct_pkg::CNT_W-1:0]  amount;

  modport source (output valid, output op, output item_key, output amount, input ready);
  modport sink   (input valid, input op, input item_key, input amount, output ready);
endinterface

interface kct_out_if;
  logic                        valid;
  logic                        ready;
  logic [kct_pkg::CNT_W-1:0]   count;
  logic                        found;
  logic                        status;
  logic [kct_pkg::USED_W-1:0]  used_entries;

  modport source (output valid, output count, output found, output status,
                  output used_entries, input ready);
  modport sink   (input valid, input count, input found, input status,
                  input used_entries, output ready);
endinterface

FILE: rtl/core/kct_alu.sv
// kct_alu: shared 32-bit add/subtract unit with equality and greater-than flags
// depends on kct_pkg
module kct_alu (
  input  kct_pkg::alu_op_t            sel,
  input  logic [kct_pkg::CNT_W-1:0]   a,
  input  logic [kct_pkg::CNT_W-1:0]   b,
  output logic [kct_pkg::CNT_W-1:0]   res,
  output kct_pkg::alu_flags_t         flags
);

  logic [kct_pkg::CNT_W:0] diff;

  // borrow out of the top bit means a < b
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    unique case (sel)
      kct_pkg::ALU_ADD: res = a + b;
      kct_pkg::ALU_SUB: res = diff[kct_pkg::CNT_W-1:0];
      default:          res = diff[kct_pkg::CNT_W-1:0];
    endcase
    flags.eq = (a == b);
    flags.gt = !diff[kct_pkg::CNT_W] && (diff[kct_pkg::CNT_W-1:0] != '0);
  end

endmodule

FILE: rtl/core/kct_mem.sv
// kct_mem: entry store, one write port and one registered read port
// depends on kct_pkg for the entry type
module kct_mem #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  kct_pkg::entry_t      wdata,
  input  logic [AW-1:0]        raddr,
  output kct_pkg::entry_t      rdata
);

  kct_pkg::entry_t mem_r [TABLE_DEPTH];
  kct_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/kct_ctrl.sv
// kct_ctrl: sequencer for search, update, append and compacting delete
// depends on kct_pkg, kct_if; drives kct_mem and kct_alu
module kct_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  kct_in_if.sink                      in_chan,
  kct_out_if.source                   out_chan,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output kct_pkg::entry_t             mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  kct_pkg::entry_t             mem_rdata,
  output kct_pkg::alu_op_t            alu_sel,
  output logic [kct_pkg::CNT_W-1:0]   alu_a,
  output logic [kct_pkg::CNT_W-1:0]   alu_b,
  input  logic [kct_pkg::CNT_W-1:0]   alu_res,
  input  kct_pkg::alu_flags_t         alu_flags
);

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_SHIFT,
    S_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [kct_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [kct_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [kct_pkg::CNT_W-1:0]    amt_r, amt_nxt;
  logic [CW-1:0]                scan_r, scan_nxt;
  logic                         pend_r, pend_nxt;
  logic [CW-1:0]                pidx_r, pidx_nxt;
  logic [CW-1:0]                slot_r, slot_nxt;
  logic                         hit_r, hit_nxt;
  logic [kct_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]                total_r, total_nxt;
  logic [kct_pkg::CNT_W-1:0]    res_r, res_nxt;
  logic                         status_r, status_nxt;
  logic [CW-1:0]                wr_back;

  assign wr_back = pidx_r - 1'b1;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    amt_nxt    = amt_r;
    scan_nxt   = scan_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    slot_nxt   = slot_r;
    hit_nxt    = hit_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    res_nxt    = res_r;
    status_nxt = status_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = scan_r[AW-1:0];
    alu_sel   = kct_pkg::ALU_SUB;
    alu_a     = mem_rdata.key;
    alu_b     = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.op;
          key_nxt   = in_chan.item_key;
          amt_nxt   = in_chan.amount;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end

      // one read issued per cycle, compare on the registered data in the next cycle
      S_SEARCH: begin
        if (pend_r && alu_flags.eq) begin
          hit_nxt   = 1'b1;
          slot_nxt  = pidx_r;
          cnt_nxt   = mem_rdata.count;
          pend_nxt  = 1'b0;
          state_nxt = S_ACT;
        end else if (scan_r >= total_r) begin
          hit_nxt   = 1'b0;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_ACT;
        end else begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r;
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_ACT: begin
        alu_a      = cnt_r;
        alu_b      = amt_r;
        alu_sel    = (op_r == kct_pkg::OP_ADD) ? kct_pkg::ALU_ADD : kct_pkg::ALU_SUB;
        status_nxt = 1'b0;
        res_nxt    = '0;
        state_nxt  = S_OUT;
        case (op_r)
          kct_pkg::OP_ADD: begin
            if (hit_r) begin
              mem_we    = 1'b1;
              mem_waddr = slot_r[AW-1:0];
              mem_wdata = '{key: key_r, count: alu_res};
              res_nxt   = alu_res;
            end else if (total_r != DEPTH_C) begin
              mem_we    = 1'b1;
              mem_waddr = total_r[AW-1:0];
              mem_wdata = '{key: key_r, count: amt_r};
              total_nxt = total_r + 1'b1;
              res_nxt   = amt_r;
            end else begin
              status_nxt = 1'b1;
            end
          end
          kct_pkg::OP_REMOVE: begin
            if (hit_r) begin
              if (alu_flags.gt) begin
                mem_we    = 1'b1;
                mem_waddr = slot_r[AW-1:0];
                mem_wdata = '{key: key_r, count: alu_res};
                res_nxt   = alu_res;
              end else begin
                // delete: pull every later entry down one place
                scan_nxt  = slot_r + 1'b1;
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
          end
          default: begin
            res_nxt = cnt_r;
          end
        endcase
      end

      S_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_back[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (scan_r < total_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r;
          scan_nxt = scan_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          total_nxt = total_r - 1'b1;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      pend_r  <= pend_nxt;
    end
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    amt_r    <= amt_nxt;
    scan_r   <= scan_nxt;
    pidx_r   <= pidx_nxt;
    slot_r   <= slot_nxt;
    hit_r    <= hit_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = (state_r == S_OUT);
  assign out_chan.count        = res_r;
  assign out_chan.found        = hit_r;
  assign out_chan.status       = status_r;
  assign out_chan.used_entries = kct_pkg::USED_W'(total_r);

endmodule

FILE: rtl/core/keyed_count_table_core.sv
// keyed_count_table_core: ordered key/count table with compacting delete
// depends on kct_pkg, kct_if, kct_alu, kct_mem, kct_ctrl
//
// Requests (add, query, remove) are handled one at a time; ready is high only
// between requests. The entry store has a single read port, so the key search
// walks the table one entry per cycle; a remove that deletes an entry then moves
// every later entry down one place. The result waits in the output register
// until taken. No clearing pass is needed after reset: only entries below the
// fill count are ever used.
module keyed_count_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  kct_in_if.sink      in_chan,
  kct_out_if.source   out_chan
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  kct_pkg::entry_t             mem_wdata;
  logic [AW-1:0]               mem_raddr;
  kct_pkg::entry_t             mem_rdata;
  kct_pkg::alu_op_t            alu_sel;
  logic [kct_pkg::CNT_W-1:0]   alu_a;
  logic [kct_pkg::CNT_W-1:0]   alu_b;
  logic [kct_pkg::CNT_W-1:0]   alu_res;
  kct_pkg::alu_flags_t         alu_flags;

  kct_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .alu_sel   (alu_sel),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_res   (alu_res),
    .alu_flags (alu_flags)
  );

  kct_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kct_alu u_alu (
    .sel   (alu_sel),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

endmodule

FILE: rtl/core/kct_chk.sv
// kct_chk: port-level checks for keyed_count_table_core, attached by bind
// depends on kct_pkg for field widths
module kct_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kct_pkg::CNT_W-1:0]   out_count,
  input logic                        out_found,
  input logic                        out_status,
  input logic [kct_pkg::USED_W-1:0]  out_used_entries
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_found)
      && $stable(out_status) && $stable(out_used_entries))
    else $error("result changed while stalled");

  // a dropped append reports a miss with no count
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_found && (out_count == '0))
    else $error("full-table result carries a count or a hit");

  // one request at a time: no new transfer while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while a result is pending");

  // an accepted request cannot produce its result in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result one cycle after transfer");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyed_count_table_core kct_chk u_kct_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_count        (out_chan.count),
  .out_found        (out_chan.found),
  .out_status       (out_chan.status),
  .out_used_entries (out_chan.used_entries)
);

FILE: dv/keyed_count_table_checker.sv
`timescale 1ns / 100ps
// keyed_count_table_checker: watches the request and result channels of the table
// and checks every result against its own table predictor; depends on kct_pkg, kct_if
module keyed_count_table_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  kct_in_if    req_mon,
  kct_out_if   res_mon,
  output int   fail_count,
  output int   pending,
  output int   request_total,
  output int   full_drops,
  output int   deletes
);

  typedef struct packed {
    logic [kct_pkg::CNT_W-1:0]  count;
    logic                       found;
    logic                       status;
    logic [kct_pkg::USED_W-1:0] used_entries;
  } tally_t;

  logic [kct_pkg::KEY_W-1:0] key_store   [TABLE_DEPTH];
  logic [kct_pkg::CNT_W-1:0] count_store [TABLE_DEPTH];
  int                        fill;
  tally_t                    expected_tallies [$];

  // updates the shadow table and returns what the block should answer
  function automatic tally_t apply_request(input logic [kct_pkg::OP_W-1:0]  op,
                                           input logic [kct_pkg::KEY_W-1:0] key,
                                           input logic [kct_pkg::CNT_W-1:0] amt);
    tally_t res;
    int     slot;
    bit     hit;
    slot = fill;
    // walk downward so the lowest matching index wins
    for (int i = fill - 1; i >= 0; i--) begin
      if (key_store[i] == key) slot = i;
    end
    hit = (slot < fill);
    res = '0;
    res.found = hit;
    if (op == kct_pkg::OP_ADD) begin
      if (hit) begin
        count_store[slot] = count_store[slot] + amt;
        res.count = count_store[slot];
      end else if (fill < TABLE_DEPTH) begin
        key_store[fill]   = key;
        count_store[fill] = amt;
        fill++;
        res.count = amt;
      end else begin
        res.status = 1'b1;
      end
    end else if (op == kct_pkg::OP_REMOVE) begin
      if (hit) begin
        if (count_store[slot] > amt) begin
          count_store[slot] = count_store[slot] - amt;
          res.count = count_store[slot];
        end else begin
          // compact: later entries move down one place
          for (int i = slot; i < fill - 1; i++) begin
            key_store[i]   = key_store[i + 1];
            count_store[i] = count_store[i + 1];
          end
          fill--;
        end
      end
    end else if (hit) begin
      res.count = count_store[slot];
    end
    res.used_entries = kct_pkg::USED_W'(fill);
    return res;
  endfunction

  always @(posedge clk) begin
    tally_t want;
    tally_t got;
    if (rst_n !== 1'b1) begin
      fill = 0;
      expected_tallies.delete();
      fail_count    = 0;
      request_total = 0;
      full_drops    = 0;
      deletes       = 0;
    end else begin
      // result side first so a transfer in the same cycle never pairs with a new request
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        got.count        = res_mon.count;
        got.found        = res_mon.found;
        got.status       = res_mon.status;
        got.used_entries = res_mon.used_entries;
        if (expected_tallies.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result count=%h found=%b status=%b used=%0d",
                     $time, got.count, got.found, got.status, got.used_entries);
          fail_count++;
        end else begin
          want = expected_tallies.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected count=%h found=%b status=%b used=%0d",
                       want.count, want.found, want.status, want.used_entries);
              $display("  actual   count=%h found=%b status=%b used=%0d",
                       got.count, got.found, got.status, got.used_entries);
            end
            fail_count++;
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        want = apply_request(req_mon.op, req_mon.item_key, req_mon.amount);
        if (want.status) full_drops++;
        if (req_mon.op == kct_pkg::OP_REMOVE && want.found && want.count == '0) deletes++;
        expected_tallies.insert(expected_tallies.size(), want);
        request_total++;
      end
    end
    pending = expected_tallies.size();
  end

endmodule

FILE: dv/keyed_count_table_core_tb.sv
`timescale 1ns / 100ps
// keyed_count_table_core_tb: drives add, query and remove traffic into the table
// core with random stalls on both channels; depends on kct_pkg, kct_if and the checker
module keyed_count_table_core_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_POOL    = 96;
  localparam int RANDOM_REQS = 450;
  localparam int QUIET_TAIL  = 60;
  localparam int CYCLE_LIMIT = 500_000;

  // opcode the block does not define; must behave as a query
  localparam logic [kct_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet;
  int   cycles;
  int   fail_count;
  int   pending;
  int   request_total;
  int   full_drops;
  int   deletes;

  logic [kct_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  kct_in_if  req_chan ();
  kct_out_if res_chan ();

  keyed_count_table_core #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  keyed_count_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_chan),
    .res_mon       (res_chan),
    .fail_count    (fail_count),
    .pending       (pending),
    .request_total (request_total),
    .full_drops    (full_drops),
    .deletes       (deletes)
  );

  always #5 clk = ~clk;

  // mostly keys from a small pool so hits, fills and deletes happen
  function automatic logic [kct_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return $urandom;
  endfunction

  // small amounts make equal-count removes common
  function automatic logic [kct_pkg::CNT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3);
    if (r < 45) return '0;
    if (r < 50) return '1;
    if (r < 70) return $urandom_range(0, 1000);
    return $urandom;
  endfunction

  task automatic send_request(input logic [kct_pkg::OP_W-1:0]  op,
                              input logic [kct_pkg::KEY_W-1:0] key,
                              input logic [kct_pkg::CNT_W-1:0] amt);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      req_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_chan.valid    <= 1'b1;
    req_chan.op       <= op;
    req_chan.item_key <= key;
    req_chan.amount   <= amt;
    do @(posedge clk); while (req_chan.ready !== 1'b1);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: ready held high or low in random runs
  initial begin : result_sink
    int   hold;
    logic level;
    hold  = 0;
    level = 1'b1;
    res_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        level = 1'b1;
        hold  = 0;
      end else if (hold == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          level = 1'b0;
          hold  = $urandom_range(1, 16);
        end else begin
          level = 1'b1;
          hold  = $urandom_range(1, 24);
        end
      end
      if (hold > 0) hold--;
      res_chan.ready <= level;
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("keyed_count_table_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    int                        r;
    int                        next_fill;
    traffic_mode_t             mode;
    logic [kct_pkg::OP_W-1:0]  op;
    logic [kct_pkg::KEY_W-1:0] key;
    quiet             = 1'b0;
    rst_n             = 1'b0;
    req_chan.valid    = 1'b0;
    req_chan.op       = kct_pkg::OP_ADD;
    req_chan.item_key = '0;
    req_chan.amount   = '0;
    next_fill         = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, wrap, partial and full removes, middle delete
    send_request(kct_pkg::OP_QUERY,  32'h0000_0000, 32'h0000_0000);
    send_request(kct_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(kct_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0000);
    send_request(kct_pkg::OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(kct_pkg::OP_ADD,    32'hFFFF_FFFF, 32'h0000_0001);
    send_request(kct_pkg::OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(kct_pkg::OP_ADD,    32'h1234_5678, 32'd100);
    send_request(kct_pkg::OP_ADD,    32'hA5A5_A5A5, 32'd7);
    send_request(kct_pkg::OP_ADD,    32'h5A5A_5A5A, 32'h8000_0000);
    send_request(kct_pkg::OP_REMOVE, 32'h1234_5678, 32'd40);
    send_request(OP_UNUSED,          32'h1234_5678, 32'hFFFF_FFFF);
    send_request(kct_pkg::OP_REMOVE, 32'h1234_5678, 32'd60);
    send_request(kct_pkg::OP_QUERY,  32'hA5A5_A5A5, 32'd0);
    send_request(kct_pkg::OP_REMOVE, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
    send_request(kct_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(kct_pkg::OP_QUERY,  32'h5A5A_5A5A, 32'd0);
    send_request(kct_pkg::OP_REMOVE, 32'h5A5A_5A5A, 32'h7FFF_FFFF);
    send_request(kct_pkg::OP_ADD,    32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_request(kct_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_UNUSED,          32'hFFFF_FFFF, 32'h0000_0000);
    wait_for_results();

    for (int idx = 0; idx < RANDOM_REQS; idx++) begin
      if (idx < 100)      mode = MODE_FILL;
      else if (idx < 175) mode = MODE_MIXED;
      else if (idx < 275) mode = MODE_DRAIN;
      else if (idx < 375) mode = MODE_FILL;
      else                mode = MODE_MIXED;
      quiet = (idx >= RANDOM_REQS - QUIET_TAIL);
      r   = $urandom_range(0, 99);
      key = pick_key();
      case (mode)
        MODE_FILL: begin
          // walk the pool so distinct keys pile up past the table depth
          if (r < 90) begin
            op  = kct_pkg::OP_ADD;
            key = key_pool[next_fill % KEY_POOL];
            next_fill++;
          end else if (r < 95) begin
            op = kct_pkg::OP_QUERY;
          end else begin
            op = kct_pkg::OP_REMOVE;
          end
        end
        MODE_DRAIN: begin
          if (r < 15)      op = kct_pkg::OP_ADD;
          else if (r < 30) op = kct_pkg::OP_QUERY;
          else             op = kct_pkg::OP_REMOVE;
        end
        default: begin
          if (r < 40)      op = kct_pkg::OP_ADD;
          else if (r < 65) op = kct_pkg::OP_QUERY;
          else if (r < 95) op = kct_pkg::OP_REMOVE;
          else             op = OP_UNUSED;
        end
      endcase
      send_request(op, key, pick_amount());
    end

    wait_for_results();
    repeat (2 * TABLE_DEPTH + 8) @(negedge clk);

    $display("ran %0d requests through fill, mixed and drain traffic with random stalls",
             request_total);
    $display("appends dropped on a full table: %0d, compacting deletes: %0d",
             full_drops, deletes);
    if (fail_count == 0 && pending == 0) begin
      $display("keyed_count_table_core_tb passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("keyed_count_table_core_tb failed");
    end
    $finish;
  end

endmodule

FILE: keyed_count_table_core.f
rtl/core/kct_pkg.sv
rtl/core/kct_if.sv
rtl/core/kct_alu.sv
rtl/core/kct_mem.sv
rtl/core/kct_ctrl.sv
rtl/core/keyed_count_table_core.sv
rtl/core/kct_chk.sv
dv/keyed_count_table_checker.sv
dv/keyed_count_table_core_tb.sv
